// ----- design/first_blocking_disc_on_segment_core_macros.svh -----
// Assertion helpers for the segment scan core.
`ifndef FIRST_BLOCKING_DISC_ON_SEGMENT_CORE_MACROS_SVH
`define FIRST_BLOCKING_DISC_ON_SEGMENT_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FBD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbd check failed");

// Next-cycle implication, checked out of reset.
`define FBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbd check failed");

`endif

// ----- design/fbd_pkg.sv -----
`default_nettype none
package fbd_pkg;

  // hazard request
  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [14:0]        radius;
    logic               is_static;
    logic               skip;
    logic               last;
  } in_item_t;

  // query result
  typedef struct packed {
    logic        found;
    logic [7:0]  hazard_index;
    logic [16:0] position_along;
    logic        overflow;
  } out_item_t;

  // serial multiplier operand widths
  localparam int unsigned MUL_W  = 31;
  localparam int unsigned PROD_W = 62;
  localparam int unsigned CNT_W  = 5;

  // request to the serial multiplier
  typedef struct packed {
    logic              start;
    logic [MUL_W-1:0]  a;
    logic [MUL_W-1:0]  b;
    logic [CNT_W-1:0]  nbits;
  } mul_req_t;

  // register indexes
  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_GOAL_X  = 3'd2;
  localparam logic [2:0] REG_GOAL_Y  = 3'd3;
  localparam logic [2:0] REG_PTIME   = 3'd4;

  // foot position of the goal end
  localparam logic [16:0] T_GOAL = 17'd65536;

endpackage
`default_nettype wire

// ----- design/fbd_mul.sv -----
`default_nettype none
// Shift-add multiplier, one bit of b per cycle, unsigned magnitudes.
module fbd_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire fbd_pkg::mul_req_t            req,
  output logic                              done,
  output logic [fbd_pkg::PROD_W-1:0]        prod
);

  logic                        run_r, run_nxt;
  logic [fbd_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [fbd_pkg::PROD_W-1:0]  acc_r, acc_nxt;
  logic [fbd_pkg::PROD_W-1:0]  a_r, a_nxt;
  logic [fbd_pkg::MUL_W-1:0]   b_r, b_nxt;

  // one partial product per cycle
  always_comb begin
    run_nxt = run_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    a_nxt   = a_r;
    b_nxt   = b_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = req.nbits;
      acc_nxt = '0;
      a_nxt   = {{(fbd_pkg::PROD_W-fbd_pkg::MUL_W){1'b0}}, req.a};
      b_nxt   = req.b;
    end else if (run_r) begin
      if (cnt_r == '0) begin
        run_nxt = 1'b0;
      end else begin
        if (b_r[0]) acc_nxt = acc_r + a_r;
        a_nxt   = {a_r[fbd_pkg::PROD_W-2:0], 1'b0};
        b_nxt   = {1'b0, b_r[fbd_pkg::MUL_W-1:1]};
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
  end

  assign done = run_r && (cnt_r == '0);
  assign prod = acc_r;

endmodule
`default_nettype wire

// ----- design/first_blocking_disc_on_segment_core.sv -----
// Scans a list of disc hazards against the start-goal segment and reports
// the nearest blocking one along the segment.
// Input channel in_valid/in_ready/in_data carries one hazard per request;
// the request flagged last closes the query. The result channel
// out_valid/out_ready/out_data carries one result per query.
// Configuration (segment ends, prediction time) goes through the APB port
// at byte addresses 0,4,8,12,16. The user must write it only while the
// block idles; the block itself does not enforce this. Each hazard runs
// through one shared shift-add multiplier (up to eleven products) and a
// 16-step restoring divider; a skipped or overflowing hazard bypasses
// both. The serial multiplier sets the rate.
// in_ready is high only between hazards. A new hazard is taken while a
// result waits; if the next last hazard finishes while the receiver still
// stalls, the block holds in its final step until out_ready.
// Reset clears the query state, the registers and out_valid.
`default_nettype none
`include "first_blocking_disc_on_segment_core_macros.svh"
module first_blocking_disc_on_segment_core #(
  parameter int unsigned MAX_HAZARDS = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fbd_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output fbd_pkg::out_item_t       out_data,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int unsigned CW = $clog2(MAX_HAZARDS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_HAZARDS);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_PRX   = 14'b00000000000010,
    S_PRY   = 14'b00000000000100,
    S_LENX  = 14'b00000000001000,
    S_LENY  = 14'b00000000010000,
    S_NUMX  = 14'b00000000100000,
    S_NUMY  = 14'b00000001000000,
    S_DIV   = 14'b00000010000000,
    S_ERRX  = 14'b00000100000000,
    S_ERRY  = 14'b00001000000000,
    S_RAD   = 14'b00010000000000,
    S_SQX   = 14'b00100000000000,
    S_SQY   = 14'b01000000000000,
    S_FIN   = 14'b10000000000000
  } state_t;

  // configuration registers
  logic signed [15:0] sx_r, sy_r, gx_r, gy_r;
  logic [11:0]        pt_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      gx_r <= '0;
      gy_r <= '0;
      pt_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        fbd_pkg::REG_START_X: sx_r <= pwdata[15:0];
        fbd_pkg::REG_START_Y: sy_r <= pwdata[15:0];
        fbd_pkg::REG_GOAL_X:  gx_r <= pwdata[15:0];
        fbd_pkg::REG_GOAL_Y:  gy_r <= pwdata[15:0];
        fbd_pkg::REG_PTIME:   pt_r <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[4:2])
      fbd_pkg::REG_START_X: prdata = {{16{sx_r[15]}}, sx_r};
      fbd_pkg::REG_START_Y: prdata = {{16{sy_r[15]}}, sy_r};
      fbd_pkg::REG_GOAL_X:  prdata = {{16{gx_r[15]}}, gx_r};
      fbd_pkg::REG_GOAL_Y:  prdata = {{16{gy_r[15]}}, gy_r};
      fbd_pkg::REG_PTIME:   prdata = {20'd0, pt_r};
      default:              prdata = '0;
    endcase
  end

  // state
  state_t              state_r, state_nxt;
  logic                mwait_r, mwait_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                bvalid_r, bvalid_nxt;
  logic [16:0]         bpos_r, bpos_nxt;
  logic [7:0]          bidx_r, bidx_nxt;
  logic                ovf_r, ovf_nxt;
  logic                out_valid_r, out_valid_nxt;
  fbd_pkg::out_item_t  out_r, out_nxt;

  // per-hazard datapath
  logic signed [19:0]  cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [15:0]  vx_r, vy_r;
  logic [14:0]         rad_r;
  logic                stat_r, last_r;
  logic [7:0]          idx_r, idx_nxt;
  logic [33:0]         len2_r, len2_nxt;
  logic signed [36:0]  num_r, num_nxt;
  logic [16:0]         t_r, t_nxt;
  logic                drun_r, drun_nxt;
  logic [3:0]          dcnt_r, dcnt_nxt;
  logic [34:0]         rem_r, rem_nxt;
  logic [15:0]         q_r, q_nxt;
  logic signed [36:0]  ex_r, ex_nxt, ey_r, ey_nxt;
  logic [61:0]         lim2_r, lim2_nxt;
  logic [62:0]         d2_r, d2_nxt;

  // derived values
  logic signed [16:0]  dx, dy;
  logic signed [19:0]  px, py;
  logic [16:0]         adx, ady, avx, avy;
  logic [19:0]         apx, apy;
  logic [36:0]         aex, aey;
  logic [30:0]         lim;
  logic [CW+7:0]       cnt_ext;
  logic [34:0]         rem2;
  logic [62:0]         d2_sum;

  assign dx  = 17'(gx_r) - 17'(sx_r);
  assign dy  = 17'(gy_r) - 17'(sy_r);
  assign px  = cx_r - 20'(sx_r);
  assign py  = cy_r - 20'(sy_r);
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);
  assign avx = vx_r[15] ? -{vx_r[15], vx_r} : {vx_r[15], vx_r};
  assign avy = vy_r[15] ? -{vy_r[15], vy_r} : {vy_r[15], vy_r};
  assign apx = px[19] ? 20'(-px) : 20'(px);
  assign apy = py[19] ? 20'(-py) : 20'(py);
  assign aex = ex_r[36] ? 37'(-ex_r) : 37'(ex_r);
  assign lim = {rad_r, 16'd0};
  assign cnt_ext = {8'd0, cnt_r};
  assign rem2 = {rem_r[33:0], 1'b0};

  // shared multiplier
  fbd_pkg::mul_req_t           mreq;
  logic                        mdone;
  logic [fbd_pkg::PROD_W-1:0]  mprod;
  logic                        neg;
  logic signed [63:0]          sprod;
  logic signed [36:0]          ey_cur;

  fbd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .done  (mdone),
    .prod  (mprod)
  );

  assign sprod  = neg ? -$signed({2'b00, mprod}) : $signed({2'b00, mprod});
  assign d2_sum = d2_r + {1'b0, mprod};

  // y error straight off the multiplier, for the box test
  assign ey_cur = sprod[36:0] - {py[19], py, 16'd0};
  assign aey    = ey_cur[36] ? 37'(-ey_cur) : 37'(ey_cur);

  // operand select for each product
  always_comb begin
    mreq = '0;
    neg  = 1'b0;
    unique case (state_r)
      S_PRX: begin
        mreq.a = 31'(avx); mreq.b = 31'(pt_r); mreq.nbits = 5'd12; neg = vx_r[15];
      end
      S_PRY: begin
        mreq.a = 31'(avy); mreq.b = 31'(pt_r); mreq.nbits = 5'd12; neg = vy_r[15];
      end
      S_LENX: begin
        mreq.a = 31'(adx); mreq.b = 31'(adx); mreq.nbits = 5'd17;
      end
      S_LENY: begin
        mreq.a = 31'(ady); mreq.b = 31'(ady); mreq.nbits = 5'd17;
      end
      S_NUMX: begin
        mreq.a = 31'(apx); mreq.b = 31'(adx); mreq.nbits = 5'd17; neg = px[19] ^ dx[16];
      end
      S_NUMY: begin
        mreq.a = 31'(apy); mreq.b = 31'(ady); mreq.nbits = 5'd17; neg = py[19] ^ dy[16];
      end
      S_ERRX: begin
        mreq.a = 31'(adx); mreq.b = 31'(t_r); mreq.nbits = 5'd17; neg = dx[16];
      end
      S_ERRY: begin
        mreq.a = 31'(ady); mreq.b = 31'(t_r); mreq.nbits = 5'd17; neg = dy[16];
      end
      S_RAD: begin
        mreq.a = 31'(rad_r); mreq.b = 31'(rad_r); mreq.nbits = 5'd15;
      end
      S_SQX: begin
        mreq.a = aex[30:0]; mreq.b = aex[30:0]; mreq.nbits = 5'd31;
      end
      S_SQY: begin
        mreq.a = ey_r[36] ? 31'(-ey_r) : 31'(ey_r);
        mreq.b = mreq.a; mreq.nbits = 5'd31;
      end
      default: ;
    endcase
    mreq.start = !(state_r == S_IDLE || state_r == S_DIV || state_r == S_FIN) && !mwait_r;
  end

  assign in_ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    mwait_nxt     = mwait_r;
    cnt_nxt       = cnt_r;
    bvalid_nxt    = bvalid_r;
    bpos_nxt      = bpos_r;
    bidx_nxt      = bidx_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    idx_nxt       = idx_r;
    len2_nxt      = len2_r;
    num_nxt       = num_r;
    t_nxt         = t_r;
    drun_nxt      = drun_r;
    dcnt_nxt      = dcnt_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    lim2_nxt      = lim2_r;
    d2_nxt        = d2_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (mreq.start) mwait_nxt = 1'b1;
    if (mdone) mwait_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cx_nxt  = 20'(in_data.center_x);
          cy_nxt  = 20'(in_data.center_y);
          idx_nxt = cnt_ext[7:0];
          if (cnt_r >= MAX_C) begin
            ovf_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            if (in_data.skip)           state_nxt = S_FIN;
            else if (in_data.is_static) state_nxt = S_LENX;
            else                        state_nxt = S_PRX;
          end
        end
      end
      S_PRX: if (mdone) begin
        cx_nxt = cx_r + 20'(sprod >>> 10);
        state_nxt = S_PRY;
      end
      S_PRY: if (mdone) begin
        cy_nxt = cy_r + 20'(sprod >>> 10);
        state_nxt = S_LENX;
      end
      S_LENX: if (mdone) begin
        len2_nxt = mprod[33:0];
        state_nxt = S_LENY;
      end
      S_LENY: if (mdone) begin
        len2_nxt = len2_r + mprod[33:0];
        state_nxt = S_NUMX;
      end
      S_NUMX: if (mdone) begin
        num_nxt = sprod[36:0];
        state_nxt = S_NUMY;
      end
      S_NUMY: if (mdone) begin
        num_nxt = num_r + sprod[36:0];
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!drun_r) begin
          priority if (len2_r == '0 || num_r[36] || num_r == '0) begin
            t_nxt = '0;
            state_nxt = S_ERRX;
          end else if (num_r[35:0] >= {2'b00, len2_r}) begin
            t_nxt = fbd_pkg::T_GOAL;
            state_nxt = S_ERRX;
          end else begin
            rem_nxt  = {1'b0, num_r[33:0]};
            q_nxt    = '0;
            dcnt_nxt = 4'd15;
            drun_nxt = 1'b1;
          end
        end else begin
          // one quotient bit per cycle
          if (rem2 >= {1'b0, len2_r}) begin
            rem_nxt = rem2 - {1'b0, len2_r};
            q_nxt   = {q_r[14:0], 1'b1};
          end else begin
            rem_nxt = rem2;
            q_nxt   = {q_r[14:0], 1'b0};
          end
          dcnt_nxt = dcnt_r - 1'b1;
          if (dcnt_r == '0) begin
            drun_nxt  = 1'b0;
            t_nxt     = {1'b0, q_nxt};
            state_nxt = S_ERRX;
          end
        end
      end
      S_ERRX: if (mdone) begin
        ex_nxt = sprod[36:0] - {px[19], px, 16'd0};
        state_nxt = S_ERRY;
      end
      S_ERRY: if (mdone) begin
        ey_nxt = ey_cur;
        if (aex < {6'd0, lim} && aey < {6'd0, lim}) state_nxt = S_RAD;
        else                                          state_nxt = S_FIN;
      end
      S_RAD: if (mdone) begin
        lim2_nxt = {mprod[29:0], 32'd0};
        state_nxt = S_SQX;
      end
      S_SQX: if (mdone) begin
        d2_nxt = {1'b0, mprod};
        state_nxt = S_SQY;
      end
      S_SQY: if (mdone) begin
        if (d2_sum < {1'b0, lim2_r} && (!bvalid_r || t_r < bpos_r)) begin
          bvalid_nxt = 1'b1;
          bpos_nxt   = t_r;
          bidx_nxt   = idx_r;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_nxt.found          = bvalid_r;
          out_nxt.hazard_index   = bidx_r;
          out_nxt.position_along = bpos_r;
          out_nxt.overflow       = ovf_r;
          out_valid_nxt = 1'b1;
          cnt_nxt    = '0;
          bvalid_nxt = 1'b0;
          bpos_nxt   = '0;
          bidx_nxt   = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mwait_r     <= 1'b0;
      cnt_r       <= '0;
      bvalid_r    <= 1'b0;
      bpos_r      <= '0;
      bidx_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      drun_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mwait_r     <= mwait_nxt;
      cnt_r       <= cnt_nxt;
      bvalid_r    <= bvalid_nxt;
      bpos_r      <= bpos_nxt;
      bidx_r      <= bidx_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      drun_r      <= drun_nxt;
    end
    out_r  <= out_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    idx_r  <= idx_nxt;
    len2_r <= len2_nxt;
    num_r  <= num_nxt;
    t_r    <= t_nxt;
    dcnt_r <= dcnt_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    ex_r   <= ex_nxt;
    ey_r   <= ey_nxt;
    lim2_r <= lim2_nxt;
    d2_r   <= d2_nxt;
    if (in_valid && in_ready) begin
      vx_r   <= in_data.vel_x;
      vy_r   <= in_data.vel_y;
      rad_r  <= in_data.radius;
      stat_r <= in_data.is_static;
      last_r <= in_data.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `FBD_ASSERT_NOW(a_ready_no_mul, in_ready, !mwait_r && !drun_r)
  `FBD_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= MAX_C)
  `FBD_ASSERT_NEXT(a_ovf_to_fin, in_valid && in_ready && cnt_r >= MAX_C, state_r == S_FIN && ovf_r)
  `FBD_ASSERT_NEXT(a_hold_result, state_r == S_FIN && last_r && out_valid && !out_ready, state_r == S_FIN)
  `FBD_ASSERT_NEXT(a_static_no_pred, in_valid && in_ready && in_data.is_static && !in_data.skip && cnt_r < MAX_C, state_r == S_LENX && stat_r)

endmodule
`default_nettype wire
